// ===== rtl/core/ddt_pkg.sv =====
// Shared constants and types for the digital delay timer.
package ddt_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int STAMP_W        = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int MODE_W         = 2;

  // Timer mode codes; the unused code acts as debounce.
  localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF_DELAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEBOUNCE  = 2'd2;

  // Register select, taken from paddr bit 2 (byte address 4*index).
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_DELAY = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [STAMP_W-1:0] delay;
  } cfg_t;

endpackage

// ===== rtl/core/ddt_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface ddt_in_if;
  logic                        valid;
  logic                        ready;
  logic [ddt_pkg::STAMP_W-1:0] now_time;
  logic                        input_level;

  modport source (output valid, output now_time, output input_level, input ready);
  modport sink   (input valid, input now_time, input input_level, output ready);
endinterface

interface ddt_out_if;
  logic valid;
  logic ready;
  logic output_level;

  modport source (output valid, output output_level, input ready);
  modport sink   (input valid, input output_level, output ready);
endinterface

// ===== rtl/core/ddt_cfg_regs.sv =====
// APB-style configuration registers: timer mode and delay.
module ddt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ddt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ddt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ddt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output ddt_pkg::cfg_t                  cfg
);

  logic [ddt_pkg::MODE_W-1:0]  mode_r;
  logic [ddt_pkg::STAMP_W-1:0] delay_r;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ddt_pkg::MODE_ON_DELAY;
      delay_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        ddt_pkg::REG_MODE:  mode_r  <= pwdata[ddt_pkg::MODE_W-1:0];
        ddt_pkg::REG_DELAY: delay_r <= pwdata[ddt_pkg::STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ddt_pkg::REG_MODE:  prdata = {{(ddt_pkg::CFG_DATA_W-ddt_pkg::MODE_W){1'b0}}, mode_r};
      ddt_pkg::REG_DELAY: prdata = delay_r;
      default:            prdata = '0;
    endcase
  end

  assign cfg.mode  = mode_r;
  assign cfg.delay = delay_r;

endmodule

// ===== rtl/core/ddt_core.sv =====
// Timer state and the per-item on-delay / off-delay / debounce update.
module ddt_core #(
  parameter int TIME_WIDTH = ddt_pkg::TIME_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ddt_pkg::cfg_t                cfg,
  input  logic                         step,
  input  logic [ddt_pkg::STAMP_W-1:0]  now_time,
  input  logic                         input_level,
  output logic                         output_level
);

  localparam logic [TIME_WIDTH-1:0] TIME_ALL1 = '1;

  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic                  first_r;
  logic                  held_r, held_nxt;

  logic [TIME_WIDTH+ddt_pkg::STAMP_W-1:0] now_wide, delay_wide;
  logic [TIME_WIDTH-1:0] now_w, delay_w;
  logic [TIME_WIDTH-1:0] el0, st0, t, rd;
  logic                  held0, ge;

  // Stamps and delay taken modulo 2^TIME_WIDTH
  assign now_wide   = {{TIME_WIDTH{1'b0}}, now_time};
  assign delay_wide = {{TIME_WIDTH{1'b0}}, cfg.delay};
  assign now_w      = now_wide[TIME_WIDTH-1:0];
  assign delay_w    = delay_wide[TIME_WIDTH-1:0];

  always_comb begin
    // First item presets elapsed to the delay; now - start is then the delay.
    el0   = first_r ? delay_w : elapsed_r;
    st0   = first_r ? (now_w - delay_w) : start_r;
    t     = first_r ? delay_w : (now_w - start_r);
    held0 = (first_r && cfg.mode[1]) ? input_level : held_r;
    // Saturate once elapsed would move backwards
    if (el0 == TIME_ALL1 || t < el0) rd = TIME_ALL1;
    else                             rd = t;
    ge = (rd >= delay_w);

    start_nxt   = st0;
    elapsed_nxt = rd;
    held_nxt    = held0;
    case (cfg.mode)
      ddt_pkg::MODE_ON_DELAY: begin
        held_nxt = 1'b0;
        if (!input_level) begin
          start_nxt   = now_w;
          elapsed_nxt = '0;
        end else begin
          held_nxt = ge;
        end
      end
      ddt_pkg::MODE_OFF_DELAY: begin
        held_nxt = 1'b1;
        if (input_level) begin
          start_nxt   = now_w;
          elapsed_nxt = '0;
        end else begin
          held_nxt = !ge;
        end
      end
      default: begin
        if (input_level == held0 || ge) begin
          held_nxt    = input_level;
          start_nxt   = now_w;
          elapsed_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      elapsed_r <= '0;
      first_r   <= 1'b1;
      held_r    <= 1'b0;
    end else if (step) begin
      start_r   <= start_nxt;
      elapsed_r <= elapsed_nxt;
      first_r   <= 1'b0;
      held_r    <= held_nxt;
    end
  end

  assign output_level = held_nxt;

endmodule

// ===== rtl/core/digital_delay_timer.sv =====
// Digital delay timer top level: input stage, timer core, result register.
//
// Input items (in_ch) carry a time stamp and an input level; each returns one
// output level on out_ch. Both channels use valid/ready; an item moves on a
// clock edge with valid and ready high.
// An accepted item lands in the input register; when out_ch is not stalled,
// the timer core updates from it and its result is loaded into the result
// register and shown valid on out_ch. Throughput: one item per cycle while
// out_ch does not stall, set by the combinational timer update between the
// two registers.
// When out_ch stalls, the result register holds; one more item waits in the
// input register, then in_ch.ready drops until the result is taken.
// Configuration (mode at 0x0, delay at 0x4) goes over the cfg_ APB port,
// writes are registered at the end of the access phase; pready is tied high.
// Write it only while no item is in flight.
// Reset (rst_n low, synchronous) empties both registers, clears the timer,
// sets mode to on-delay, delay to zero and arms the first-item preset.
module digital_delay_timer #(
  parameter int TIME_WIDTH = ddt_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ddt_in_if.sink                         in_ch,
  ddt_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ddt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ddt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ddt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  ddt_pkg::cfg_t cfg;

  logic                        s1_valid_r;
  logic [ddt_pkg::STAMP_W-1:0] s1_now_r;
  logic                        s1_level_r;
  logic                        out_valid_r;
  logic                        out_level_r;
  logic                        advance;
  logic                        core_level;

  ddt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ddt_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (advance),
    .now_time     (s1_now_r),
    .input_level  (s1_level_r),
    .output_level (core_level)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance)           out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_now_r   <= in_ch.now_time;
      s1_level_r <= in_ch.input_level;
    end
    if (advance) out_level_r <= core_level;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.output_level = out_level_r;

endmodule
